// ===== src/flg_pkg.sv =====
`default_nettype none
package flg_pkg;

  // store, table and phase sizes
  localparam int DELAY_DEPTH  = 2048;
  localparam int SINE_ENTRIES = 1024;
  localparam int PHASE_BITS   = 24;

  localparam int DELAY_AW = $clog2(DELAY_DEPTH);
  localparam int SINE_AW  = $clog2(SINE_ENTRIES);
  localparam int RD_W     = DELAY_AW + 8;
  localparam int DLY_W    = (RD_W > 20) ? RD_W + 1 : 21;
  localparam logic [DLY_W-1:0] MAX_DELAY = DLY_W'(DELAY_DEPTH - 2) << 8;

  // shared multiplier
  localparam int MUL_W  = 20;
  localparam int PROD_W = 2 * MUL_W;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_BASE_DELAY    = 3'd1,
    REG_DELAY_SWEEP   = 3'd2,
    REG_FEEDBACK_GAIN = 3'd3,
    REG_WET_MIX       = 3'd4
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SWEEP, S_DELAY, S_RD0, S_RD1,
    S_IMUL, S_INTERP, S_FBMUL, S_WRITE, S_MIX
  } state_t;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE, MUL_SWEEP, MUL_INTERP, MUL_FEEDBACK, MUL_MIX
  } mul_sel_t;

  typedef struct packed {
    logic                in_rdy;
    mul_sel_t            mul_sel;
    logic                mem_re;
    logic                rd_next;
    logic                ld_rd;
    logic                ld_d0;
    logic                ld_dly;
    logic                mem_we;
    logic                clr;
    logic [DELAY_AW-1:0] clr_addr;
    logic                ld_out;
  } ctrl_t;

  // lfo table: (sin + 1) / 2 in q1.15
  typedef logic [15:0] lfo_tab_t [SINE_ENTRIES];

  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q30     = 64'd1073741824;
  localparam longint TAYLOR_DIV [5] = '{6, 20, 42, 72, 110};

  function automatic lfo_tab_t build_lfo();
    lfo_tab_t t;
    longint unsigned th, th2, mag, r, u;
    longint sum, s;
    longint unsigned q;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      u = 64'(4 * k);
      q = u / SINE_ENTRIES;
      r = u % SINE_ENTRIES;
      if (q == 1 || q == 3) r = SINE_ENTRIES - r;
      th  = (HALF_PI_Q30 * r) / SINE_ENTRIES;
      th2 = (th * th) >> 30;
      mag = th;
      sum = longint'(th);
      for (int j = 0; j < 5; j++) begin
        mag = (mag * th2) >> 30;
        mag = mag / TAYLOR_DIV[j];
        if (j % 2 == 0) sum = sum - longint'(mag);
        else sum = sum + longint'(mag);
      end
      s = (q >= 2) ? -sum : sum;
      if (s > ONE_Q30) s = ONE_Q30;
      if (s < -ONE_Q30) s = -ONE_Q30;
      t[k] = 16'((s + ONE_Q30 + 32768) >>> 16);
    end
    return t;
  endfunction

  localparam lfo_tab_t LFO_TABLE = build_lfo();

endpackage
`default_nettype wire

// ===== src/flanger_with_feedback_unit.sv =====
`default_nettype none
// Flanger with feedback on signed 16-bit samples. After reset the block
// clears its 2048-entry delay store, one entry per cycle, and holds in_stall
// high while it clears; configuration writes are taken at any time.
// No new sample is taken until the block is through with the last one: one
// shared multiplier is used four times in turn (sweep times lfo,
// interpolation, feedback, dry/wet mix), and the delay store with its one
// read port is read twice and written once per sample. The result sits in
// an output register, so the next sample is taken while it waits; the last
// step waits only if that register is still full and stalled.
module flanger_with_feedback_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire logic signed [15:0] in_sample,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] out_sample,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [22:0]  cfg_data
);
  import flg_pkg::*;

  ctrl_t ctrl;

  // configuration registers
  logic [22:0]        phase_step_r;
  logic [18:0]        base_delay_r, delay_sweep_r;
  logic signed [15:0] feedback_gain_r;
  logic [15:0]        wet_mix_r;

  // datapath state
  logic [PHASE_BITS-1:0] phase_r;
  logic [DELAY_AW-1:0]   wp_r;
  logic signed [15:0]    x_r, d0_r, dly_r;
  logic [RD_W-1:0]       rd_r;
  logic                  out_valid_r;
  logic signed [15:0]    out_sample_r;
  logic [15:0]           lfo_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r, prod_rnd, itp;
  logic signed [19:0]       prod_q, qsum;
  logic signed [15:0]       sat_q, mem_q;
  logic [DLY_W-1:0]         dly_raw, dly_clamp;
  logic [15:0]              wet_m;
  logic                     out_free;
  logic [DELAY_AW-1:0]      i0, raddr, waddr;
  logic signed [15:0]       wdata;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !ctrl.in_rdy;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // sequencer
  flg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // registered lfo table read, phase only moves when a result is loaded
  always_ff @(posedge clk) begin
    lfo_r <= LFO_TABLE[phase_r[PHASE_BITS-1 -: SINE_AW]];
  end

  // shared multiplier operand select
  assign wet_m = (wet_mix_r > 16'd32768) ? 16'd32768 : wet_mix_r;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      MUL_SWEEP: begin
        mul_a = MUL_W'($signed({1'b0, delay_sweep_r}));
        mul_b = MUL_W'($signed({1'b0, lfo_r}));
      end
      MUL_INTERP: begin
        mul_a = MUL_W'(17'(mem_q) - 17'(d0_r));
        mul_b = MUL_W'($signed({1'b0, rd_r[7:0]}));
      end
      MUL_FEEDBACK: begin
        mul_a = MUL_W'(dly_r);
        mul_b = MUL_W'(feedback_gain_r);
      end
      MUL_MIX: begin
        mul_a = MUL_W'(17'(dly_r) - 17'(x_r));
        mul_b = MUL_W'($signed({1'b0, wet_m}));
      end
      default: ;
    endcase
  end

  flg_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // round-half-up of product / 2^15, then add the dry sample and saturate
  assign prod_rnd = prod_r + PROD_W'(16384);
  assign prod_q   = $signed(prod_rnd[34:15]);
  assign qsum     = 20'(x_r) + prod_q;
  assign sat_q    = sat16(qsum);

  // delay in samples q.8, clamped
  assign dly_raw   = DLY_W'(base_delay_r) + DLY_W'(prod_rnd[PROD_W-1:15]);
  assign dly_clamp = (dly_raw > MAX_DELAY) ? MAX_DELAY : dly_raw;

  // interpolation: d0*256 + (d1-d0)*frac, rounded
  assign itp = (PROD_W'(d0_r) <<< 8) + prod_r + PROD_W'(128);

  // delay store ports
  assign i0    = rd_r[RD_W-1:8];
  assign raddr = ctrl.rd_next ? i0 + 1'b1 : i0;
  assign waddr = ctrl.clr ? ctrl.clr_addr : wp_r;
  assign wdata = ctrl.clr ? 16'sd0 : sat_q;

  flg_mem u_mem (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctrl.mem_re),
    .raddr (raddr),
    .rdata (mem_q)
  );

  // config write transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= '0;
      base_delay_r    <= '0;
      delay_sweep_r   <= '0;
      feedback_gain_r <= '0;
      wet_mix_r       <= 16'd16384;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHASE_STEP:    phase_step_r    <= cfg_data;
        REG_BASE_DELAY:    base_delay_r    <= cfg_data[18:0];
        REG_DELAY_SWEEP:   delay_sweep_r   <= cfg_data[18:0];
        REG_FEEDBACK_GAIN: feedback_gain_r <= $signed(cfg_data[15:0]);
        REG_WET_MIX:       wet_mix_r       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // control state: phase, write pointer, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.mem_we && !ctrl.clr) wp_r <= wp_r + 1'b1;
      if (ctrl.ld_out) begin
        phase_r     <= phase_r + PHASE_BITS'(phase_step_r);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.in_rdy && in_valid) x_r <= in_sample;
    if (ctrl.ld_rd) rd_r <= RD_W'({wp_r, 8'd0}) - RD_W'(dly_clamp);
    if (ctrl.ld_d0) d0_r <= mem_q;
    if (ctrl.ld_dly) dly_r <= itp[23:8];
    if (ctrl.ld_out) out_sample_r <= sat_q;
  end

  // checks
  a_out_never_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ld_out |-> out_free)
    else $error("result loaded while output register is full and stalled");

  a_wp_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.mem_we && !ctrl.clr) |=> wp_r == $past(wp_r) + 1'b1)
    else $error("write pointer did not advance after a sample write");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.mem_re || ctrl.mem_we) |-> in_stall)
    else $error("input accepted while the store is in use");

  a_out_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !ctrl.ld_out) |=> !out_valid)
    else $error("output valid held after its transaction");

endmodule
`default_nettype wire

// ===== src/flg_mul.sv =====
`default_nettype none
module flg_mul (
  input  wire                              clk,
  input  wire logic signed [flg_pkg::MUL_W-1:0]  a,
  input  wire logic signed [flg_pkg::MUL_W-1:0]  b,
  output logic signed [flg_pkg::PROD_W-1:0]      prod_r
);
  import flg_pkg::*;

  // registered signed product
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule
`default_nettype wire

// ===== src/flg_mem.sv =====
`default_nettype none
module flg_mem (
  input  wire                                clk,
  input  wire                                we,
  input  wire logic [flg_pkg::DELAY_AW-1:0]  waddr,
  input  wire logic signed [15:0]            wdata,
  input  wire                                re,
  input  wire logic [flg_pkg::DELAY_AW-1:0]  raddr,
  output logic signed [15:0]                 rdata
);
  import flg_pkg::*;

  logic signed [15:0] mem [DELAY_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/flg_ctrl.sv =====
`default_nettype none
module flg_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  input  wire            out_free,
  output flg_pkg::ctrl_t ctrl
);
  import flg_pkg::*;

  state_t state_r, state_nxt;
  logic [DELAY_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) state_nxt = S_IDLE;
      end
      S_IDLE:   if (in_valid) state_nxt = S_SWEEP;
      S_SWEEP:  state_nxt = S_DELAY;
      S_DELAY:  state_nxt = S_RD0;
      S_RD0:    state_nxt = S_RD1;
      S_RD1:    state_nxt = S_IMUL;
      S_IMUL:   state_nxt = S_INTERP;
      S_INTERP: state_nxt = S_FBMUL;
      S_FBMUL:  state_nxt = S_WRITE;
      S_WRITE:  state_nxt = S_MIX;
      S_MIX:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    ctrl          = '0;
    ctrl.mul_sel  = MUL_NONE;
    ctrl.clr_addr = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        ctrl.mem_we = 1'b1;
        ctrl.clr    = 1'b1;
      end
      S_IDLE:   ctrl.in_rdy = 1'b1;
      S_SWEEP:  ctrl.mul_sel = MUL_SWEEP;
      S_DELAY:  ctrl.ld_rd = 1'b1;
      S_RD0:    ctrl.mem_re = 1'b1;
      S_RD1: begin
        ctrl.mem_re  = 1'b1;
        ctrl.rd_next = 1'b1;
        ctrl.ld_d0   = 1'b1;
      end
      S_IMUL:   ctrl.mul_sel = MUL_INTERP;
      S_INTERP: ctrl.ld_dly = 1'b1;
      S_FBMUL:  ctrl.mul_sel = MUL_FEEDBACK;
      S_WRITE: begin
        ctrl.mem_we  = 1'b1;
        ctrl.mul_sel = MUL_MIX;
      end
      // keep the mix product in place while the output register is busy
      S_MIX: begin
        ctrl.mul_sel = MUL_MIX;
        ctrl.ld_out  = out_free;
      end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/flanger_with_feedback_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module flanger_with_feedback_unit_tb;
  import flg_pkg::*;

  // prediction of the flanger: lfo table, delay store, mixing
  class flange_scoreboard;
    logic signed [15:0] store [DELAY_DEPTH];
    int unsigned        wpos;
    logic [23:0]        phase;
    int unsigned        lfo [SINE_ENTRIES];
    logic [22:0]        step_r;
    logic [18:0]        base_r, sweep_r;
    logic signed [15:0] fb_r;
    logic [15:0]        wet_r;
    logic signed [15:0] expected_q [$];
    int                 errors;

    function new();
      for (int k = 0; k < SINE_ENTRIES; k++) lfo[k] = lfo_value(k);
      foreach (store[i]) store[i] = '0;
      wpos = 0;
      phase = '0;
      step_r = '0;
      base_r = '0;
      sweep_r = '0;
      fb_r = '0;
      wet_r = 16'd16384;
      errors = 0;
    endfunction

    // sin(pi/2 * r / n) in q30, truncated taylor terms
    function longint quarter(longint unsigned r);
      longint unsigned th, th2, mag;
      longint sum;
      th = (64'd1686629713 * r) / SINE_ENTRIES;
      th2 = (th * th) >> 30;
      mag = th;
      sum = longint'(th);
      for (int k = 2; k <= 10; k += 2) begin
        mag = (mag * th2) >> 30;
        mag = mag / (k * (k + 1));
        if ((k & 2) != 0) sum -= longint'(mag);
        else sum += longint'(mag);
      end
      return sum;
    endfunction

    function int unsigned lfo_value(int k);
      int q, r;
      longint s;
      q = (4 * k) / SINE_ENTRIES;
      r = (4 * k) % SINE_ENTRIES;
      case (q)
        0: s = quarter(r);
        1: s = quarter(SINE_ENTRIES - r);
        2: s = -quarter(r);
        default: s = -quarter(SINE_ENTRIES - r);
      endcase
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      if (s < -64'sd1073741824) s = -64'sd1073741824;
      return int'((s + 64'sd1073741824 + 32768) >>> 16);
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint round_q15(longint v);
      return (v + 16384) >>> 15;
    endfunction

    function void write_reg(cfg_reg_t r, logic [22:0] d);
      case (r)
        REG_PHASE_STEP:    step_r = d;
        REG_BASE_DELAY:    base_r = d[18:0];
        REG_DELAY_SWEEP:   sweep_r = d[18:0];
        REG_FEEDBACK_GAIN: fb_r = d[15:0];
        REG_WET_MIX:       wet_r = d[15:0];
        default: ;
      endcase
    endfunction

    // accepted input transaction: advance state, queue the mixed sample
    function void note_sample(logic signed [15:0] x);
      longint unsigned dly, rd, i0, i1, frac, span, mix;
      longint d0, d1, delayed, fed, y, xs;
      xs = x;
      span = longint'(DELAY_DEPTH) << 8;
      dly = base_r + ((longint'(sweep_r) * lfo[phase[23:14]] + 16384) >> 15);
      if (dly > (longint'(DELAY_DEPTH - 2) << 8)) dly = longint'(DELAY_DEPTH - 2) << 8;
      rd = ((longint'(wpos) << 8) + span - dly) % span;
      i0 = rd >> 8;
      frac = rd & 255;
      i1 = (i0 + 1) % DELAY_DEPTH;
      d0 = longint'(store[i0]) + 32768;
      d1 = longint'(store[i1]) + 32768;
      delayed = ((d0 * (256 - frac) + d1 * frac + 128) >> 8) - 32768;
      fed = sat16(xs + round_q15(delayed * longint'(fb_r)));
      store[wpos] = fed[15:0];
      wpos = (wpos + 1) % DELAY_DEPTH;
      mix = (wet_r > 32768) ? 32768 : wet_r;
      y = sat16(round_q15(longint'(32768 - mix) * xs + longint'(mix) * delayed));
      expected_q.push_back(y[15:0]);
      phase = phase + step_r;
    endfunction

    function void check_sample(logic signed [15:0] y);
      logic signed [15:0] e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected out_sample %0d", $time, y);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (y !== e) begin
        $display("%0t: out_sample expected %0d actual %0d", $time, e, y);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] in_sample, out_sample;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [22:0] cfg_data;
  logic hold_req;
  int idle_cycles;
  flange_scoreboard sb;

  flanger_with_feedback_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor both channels and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) sb.note_sample(in_sample);
      if (out_valid && !out_stall) sb.check_sample(out_sample);
      if (idle_cycles > 20000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver stalls: short runs mostly, a few long, one long hold on request
  initial begin
    int len;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        len = $urandom_range(99);
        if (len < 20) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else if (len < 23) begin
          out_stall <= 1'b1;
          len = $urandom_range(20, 60);
        end else begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 10);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  task automatic write_cfg(cfg_reg_t r, logic [22:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(r, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(logic [22:0] st, logic [18:0] bd, logic [18:0] sw,
                         logic [15:0] fb, logic [15:0] wm);
    write_cfg(REG_PHASE_STEP, st);
    write_cfg(REG_BASE_DELAY, 23'(bd));
    write_cfg(REG_DELAY_SWEEP, 23'(sw));
    write_cfg(REG_FEEDBACK_GAIN, 23'(fb));
    write_cfg(REG_WET_MIX, 23'(wm));
  endtask

  // one input transaction, then a random gap
  task automatic send_sample(logic signed [15:0] x);
    int g;
    in_valid <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (in_stall);
    g = $urandom_range(99);
    if (g < 60) g = 0;
    else if (g < 95) g = $urandom_range(1, 4);
    else g = $urandom_range(10, 80);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [18:0] rand_delay();
    case ($urandom_range(5))
      0: return 19'h7FFFF;
      1: return 19'd0;
      2: return 19'($urandom_range(523776));
      default: return 19'($urandom_range(60 * 256));
    endcase
  endfunction

  initial begin
    logic signed [15:0] corner [11];
    logic [22:0] st;
    logic [15:0] fb, wm;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    idle_cycles = 0;
    corner = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
               16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5555, 16'shAAAA};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // zero delay, full positive feedback, fully wet, fastest lfo
    set_all(23'h7FFFFF, 19'd0, 19'd0, 16'h7FFF, 16'd32768);
    foreach (corner[i]) send_sample(corner[i]);
    drain();
    // delay clamped, full negative feedback, wet mix above full
    set_all(23'd0, 19'h7FFFF, 19'h7FFFF, 16'h8000, 16'hFFFF);
    foreach (corner[i]) send_sample(corner[i]);
    drain();

    // random phases, one of them with a long receiver hold
    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(3))
        0: st = 23'h7FFFFF;
        1: st = 23'd0;
        2: st = 23'($urandom);
        default: st = 23'($urandom_range(20000));
      endcase
      case ($urandom_range(3))
        0: fb = 16'h8000;
        1: fb = 16'h7FFF;
        default: fb = 16'($urandom);
      endcase
      case ($urandom_range(4))
        0: wm = 16'd0;
        1: wm = 16'd32768;
        2: wm = 16'hFFFF;
        default: wm = 16'($urandom);
      endcase
      set_all(st, rand_delay(), rand_delay(), fb, wm);
      if (p == 3) hold_req = 1'b1;
      repeat (128) send_sample(rand_sample());
      drain();
    end

    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
